FILE: rtl/awt_pkg.sv
package awt_pkg;

  // fixed field widths
  localparam int LEVEL_BITS = 2;
  localparam int MODE_BITS  = 2;
  localparam int CNT_BITS   = 32;
  localparam int TOTAL_BITS = 64;
  localparam int IDX_BITS   = 3;

  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [MODE_BITS-1:0]  mode_t;
  typedef logic [IDX_BITS-1:0]   reg_idx_t;

  // level codes
  localparam level_t LVL_LOW  = 2'd0;
  localparam level_t LVL_WIN  = 2'd1;
  localparam level_t LVL_HIGH = 2'd2;

  // trigger modes
  localparam mode_t MODE_OFF   = 2'd0;
  localparam mode_t MODE_STATE = 2'd1;
  localparam mode_t MODE_RISE  = 2'd2;
  localparam mode_t MODE_FALL  = 2'd3;

  // input operations
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // register indexes
  localparam reg_idx_t REG_MODE     = 3'd0;
  localparam reg_idx_t REG_LOW_TH   = 3'd1;
  localparam reg_idx_t REG_HIGH_TH  = 3'd2;
  localparam reg_idx_t REG_ACC_EN   = 3'd3;
  localparam reg_idx_t REG_CENTER   = 3'd4;
  localparam reg_idx_t REG_DEADBAND = 3'd5;

endpackage

FILE: rtl/awt_if.sv
// sample / command channel
interface awt_in_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink (input valid, input operation, input sample, output ready);
endinterface

// result channel
interface awt_out_if import awt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  level_t                trigger_state;
  logic                  trigger_pulse;
  logic [TOTAL_BITS-1:0] accum_total;
  logic [CNT_BITS-1:0]   accum_samples;

  modport source (output valid, output trigger_state, output trigger_pulse,
                  output accum_total, output accum_samples, input ready);
  modport sink (input valid, input trigger_state, input trigger_pulse,
                input accum_total, input accum_samples, output ready);
endinterface

// register write channel
interface awt_cfg_if import awt_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  reg_idx_t               index;
  logic [SAMPLE_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/awt_cfg.sv
module awt_cfg import awt_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  awt_cfg_if.sink                cfg_ch,
  output mode_t                  mode,
  output logic [SAMPLE_BITS-1:0] low_th,
  output logic [SAMPLE_BITS-1:0] high_th,
  output logic                   acc_en,
  output logic [SAMPLE_BITS-1:0] center,
  output logic [SAMPLE_BITS-1:0] deadband,
  output logic                   acc_clr
);

  // 0.8 V and 2.0 V codes of a 3.3 V full scale, rounded
  localparam int LowThInit  = (16 * (2 ** SAMPLE_BITS) + 33) / 66;
  localparam int HighThInit = (40 * (2 ** SAMPLE_BITS) + 33) / 66;

  logic                   wr;
  mode_t                  mode_r;
  logic [SAMPLE_BITS-1:0] low_th_r;
  logic [SAMPLE_BITS-1:0] high_th_r;
  logic                   acc_en_r;
  logic [SAMPLE_BITS-1:0] center_r;
  logic [SAMPLE_BITS-1:0] deadband_r;

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_OFF;
      low_th_r   <= SAMPLE_BITS'(LowThInit);
      high_th_r  <= SAMPLE_BITS'(HighThInit);
      acc_en_r   <= 1'b0;
      center_r   <= '0;
      deadband_r <= '0;
    end else if (wr) begin
      case (cfg_ch.index)
        REG_MODE:     mode_r     <= cfg_ch.data[MODE_BITS-1:0];
        REG_LOW_TH:   low_th_r   <= cfg_ch.data;
        REG_HIGH_TH:  high_th_r  <= cfg_ch.data;
        REG_ACC_EN:   acc_en_r   <= cfg_ch.data[0];
        REG_CENTER:   center_r   <= cfg_ch.data;
        REG_DEADBAND: deadband_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // any enable write restarts the accumulator
  assign acc_clr  = wr && (cfg_ch.index == REG_ACC_EN);
  assign mode     = mode_r;
  assign low_th   = low_th_r;
  assign high_th  = high_th_r;
  assign acc_en   = acc_en_r;
  assign center   = center_r;
  assign deadband = deadband_r;

endmodule

FILE: rtl/awt_trig.sv
module awt_trig import awt_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   is_smp,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  mode_t                  mode,
  input  logic [SAMPLE_BITS-1:0] low_th,
  input  logic [SAMPLE_BITS-1:0] high_th,
  output level_t                 level_nxt,
  output logic                   pulse
);

  level_t level_r;
  logic   outside_r;
  logic   outside_nxt;
  level_t lvl_cls;
  logic   hi;
  logic   active;
  logic   change;

  // classify, low test first
  always_comb begin
    if (sample <= low_th) begin
      lvl_cls = LVL_LOW;
    end else if (sample >= high_th) begin
      lvl_cls = LVL_HIGH;
    end else begin
      lvl_cls = LVL_WIN;
    end
  end

  // edge on last non-window level
  assign hi          = (lvl_cls == LVL_HIGH);
  assign active      = is_smp && (mode != MODE_OFF);
  assign change      = active && (lvl_cls != LVL_WIN) && (hi != outside_r);
  assign pulse       = change && ((hi && (mode == MODE_RISE)) ||
                                  (!hi && (mode == MODE_FALL)));
  assign level_nxt   = active ? lvl_cls : level_r;
  assign outside_nxt = change ? hi : outside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= LVL_LOW;
      outside_r <= 1'b0;
    end else if (adv) begin
      level_r   <= level_nxt;
      outside_r <= outside_nxt;
    end
  end

endmodule

FILE: rtl/awt_acc.sv
module awt_acc import awt_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_BITS    = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   acc_clr,
  input  logic                   is_clr,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   acc_en,
  input  logic [SAMPLE_BITS-1:0] center,
  input  logic [SAMPLE_BITS-1:0] deadband,
  output logic [SUM_BITS-1:0]    sum_nxt,
  output logic [CNT_BITS-1:0]    cnt_nxt
);

  logic [SUM_BITS-1:0]           sum_r;
  logic [CNT_BITS-1:0]           cnt_r;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]          mag;
  logic signed [SAMPLE_BITS:0]   diff_db;
  logic [SUM_BITS-1:0]           addend;

  // centered value with deadband, or the raw sample when center is zero
  assign diff    = $signed({1'b0, sample}) - $signed({1'b0, center});
  assign mag     = diff[SAMPLE_BITS] ? $unsigned(-diff) : $unsigned(diff);
  assign diff_db = (mag <= {1'b0, deadband}) ? '0 : diff;
  assign addend  = (center != '0) ? SUM_BITS'(diff_db) : SUM_BITS'(sample);

  // next sum and count
  always_comb begin
    if (is_clr) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end else if (acc_en) begin
      sum_nxt = sum_r + addend;
      cnt_nxt = cnt_r + CNT_BITS'(1);
    end else begin
      sum_nxt = sum_r;
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (acc_clr) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (adv) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/analog_window_trigger_accumulator_core.sv
// each accepted word passes the input register, then the result register
// throughput: one word per cycle if out_ch is ready, single add and compare stage
// the input register refills while a finished result waits in the output register
// reset (synchronous, rst_n low) clears levels, sum, count and both stage valids
// and loads the registers with their power-on values
module analog_window_trigger_accumulator_core import awt_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_BITS    = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  awt_in_if.sink    in_ch,
  awt_out_if.source out_ch,
  awt_cfg_if.sink   cfg_ch
);

  mode_t                  mode;
  logic [SAMPLE_BITS-1:0] low_th;
  logic [SAMPLE_BITS-1:0] high_th;
  logic                   acc_en;
  logic [SAMPLE_BITS-1:0] center;
  logic [SAMPLE_BITS-1:0] deadband;
  logic                   acc_clr;

  logic                   s1_valid_r;
  logic                   s1_op_r;
  logic [SAMPLE_BITS-1:0] s1_smp_r;
  logic                   adv;
  logic                   is_smp;
  logic                   is_clr;

  level_t                 level_nxt;
  logic                   pulse;
  logic [SUM_BITS-1:0]    sum_nxt;
  logic [CNT_BITS-1:0]    cnt_nxt;

  logic                   out_valid_r;
  level_t                 out_state_r;
  logic                   out_pulse_r;
  logic [TOTAL_BITS-1:0]  out_total_r;
  logic [CNT_BITS-1:0]    out_cnt_r;

  awt_cfg #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_ch   (cfg_ch),
    .mode     (mode),
    .low_th   (low_th),
    .high_th  (high_th),
    .acc_en   (acc_en),
    .center   (center),
    .deadband (deadband),
    .acc_clr  (acc_clr)
  );

  // stage handshake
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign is_smp      = (s1_op_r == OP_SAMPLE);
  assign is_clr      = (s1_op_r == OP_CLEAR);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r  <= in_ch.operation;
      s1_smp_r <= in_ch.sample;
    end
  end

  awt_trig #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .is_smp    (is_smp),
    .sample    (s1_smp_r),
    .mode      (mode),
    .low_th    (low_th),
    .high_th   (high_th),
    .level_nxt (level_nxt),
    .pulse     (pulse)
  );

  awt_acc #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .acc_clr  (acc_clr),
    .is_clr   (is_clr),
    .sample   (s1_smp_r),
    .acc_en   (acc_en),
    .center   (center),
    .deadband (deadband),
    .sum_nxt  (sum_nxt),
    .cnt_nxt  (cnt_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_state_r <= level_nxt;
      out_pulse_r <= pulse;
      out_total_r <= TOTAL_BITS'($signed(sum_nxt));
      out_cnt_r   <= cnt_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.trigger_state = out_state_r;
  assign out_ch.trigger_pulse = out_pulse_r;
  assign out_ch.accum_total   = out_total_r;
  assign out_ch.accum_samples = out_cnt_r;

endmodule
